/* hdl/msq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msq_pkg
// Shared types and constants for the modulation magnitude square root block.
// ----------------------------------------------------------------------------
package msq_pkg;

   // Operation codes
   localparam logic OP_MAGNITUDE = 1'b0;   // sqrt(ud^2 + uq^2)
   localparam logic OP_QLIMIT    = 1'b1;   // sqrt(max^2 - ud^2)

   // Reset value of the maximum modulation index (2/sqrt(3) in Q15)
   localparam logic [15:0] MAX_MOD_RESET = 16'd37837;

   // Seed shift thresholds and shifts
   localparam logic [31:0] SEED_THR_LO  = 32'd10000;
   localparam logic [31:0] SEED_THR_MID = 32'd10000000;
   localparam logic [31:0] SEED_THR_HI  = 32'd1000000000;
   localparam logic [4:0]  SEED_SH_LO   = 5'd5;
   localparam logic [4:0]  SEED_SH_MID  = 5'd9;
   localparam logic [4:0]  SEED_SH_HI   = 5'd13;
   localparam logic [4:0]  SEED_SH_TOP  = 5'd15;

   // Bound on Newton steps
   localparam logic [6:0]  STEP_LIMIT = 7'd64;

   // Divider width
   localparam int unsigned DIV_BITS = 32;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ_D,
      ST_SQ_B,
      ST_RAD,
      ST_SEED,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_UPDATE
   } msq_state_type;

   // Divider status towards the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } msq_div_stat_type;

endpackage

/* hdl/msq_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msq_div
// Restoring unsigned divider, one quotient bit per clock cycle.
// ----------------------------------------------------------------------------
module msq_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [31:0]                   dividend,
   input  logic [31:0]                   divisor,
   output logic [31:0]                   quotient,
   output msq_pkg::msq_div_stat_type     stat
);
   import msq_pkg::*;

   localparam int unsigned CNT_W = $clog2(DIV_BITS + 1);

   logic [31:0]      rem_ff, rem_in;
   logic [31:0]      quo_ff, quo_in;
   logic [31:0]      dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;

   logic [32:0]      shifted;
   logic [32:0]      trial;
   logic             fits;

   // one trial subtraction per cycle
   assign shifted = {rem_ff, quo_ff[31]};
   assign trial   = shifted - {1'b0, dvs_ff};
   assign fits    = (shifted >= {1'b0, dvs_ff});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
         cnt_in = CNT_W'(DIV_BITS);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? trial[31:0] : shifted[31:0];
         quo_in = {quo_ff[30:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = run_ff;
   assign stat.done = done_ff;

endmodule

/* hdl/modulation_magnitude_sqrt_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modulation_magnitude_sqrt_top
// Newton integer square root of ud^2+uq^2 or max^2-ud^2 for Q15 inputs.
// Sequence: the two squares are formed in turn, then the radicand and the seed;
//   each Newton step is a bit-serial divide on the shared divider plus hand-off
//   and update, for at most STEP_LIMIT steps.
// Throughput: one transaction at a time; busy stays high until the result
//   strobe, and the shared divider sets the pace.
// Reset: synchronous, clears the sequencer and restores max_modulation.
// The result is strobed for one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module modulation_magnitude_sqrt_top (
   input  logic               clock,
   input  logic               reset,
   // request
   input  logic               start,
   output logic               busy,
   input  logic               req_opcode,
   input  logic signed [16:0] req_ud,
   input  logic signed [16:0] req_uq,
   // response
   output logic               rsp_valid,
   output logic [15:0]        rsp_root,
   // configuration
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data
);
   import msq_pkg::*;

   msq_state_type    state_ff, state_in;

   logic [15:0]      max_mod_ff;
   logic             op_ff, op_in;
   logic [16:0]      ud_ff, ud_in;
   logic [16:0]      uq_ff, uq_in;
   logic [32:0]      ud2_ff, ud2_in;
   logic [32:0]      b2_ff, b2_in;
   logic [31:0]      rad_ff, rad_in;
   logic [31:0]      x_ff, x_in;
   logic [6:0]       n_ff, n_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      rsp_root_ff, rsp_root_in;

   logic [16:0]      mul_opd;
   logic [33:0]      mul_prod;
   logic [16:0]      ud_abs;
   logic [16:0]      uq_abs;
   logic [33:0]      sum_sq;
   logic [4:0]       seed_sh;
   logic [32:0]      newton_sum;
   logic [31:0]      x_new;
   logic [31:0]      x_diff;
   logic [6:0]       n_next;
   logic [31:0]      x_final;

   logic             div_start;
   logic [31:0]      div_quo;
   msq_div_stat_type div_stat;

   // shared iterative divider
   msq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rad_ff),
      .divisor  (x_ff),
      .quotient (div_quo),
      .stat     (div_stat)
   );

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_mod_ff <= MAX_MOD_RESET;
      end else if (csr_wr_en) begin
         max_mod_ff <= csr_wr_data;
      end
   end

   // magnitudes of the signed operands
   assign ud_abs = ud_ff[16] ? (~ud_ff + 17'd1) : ud_ff;
   assign uq_abs = uq_ff[16] ? (~uq_ff + 17'd1) : uq_ff;

   // one squaring multiplier, shared by the ST_SQ_D and ST_SQ_B states
   assign mul_opd  = (state_ff == ST_SQ_D) ? ud_abs :
                     (op_ff == OP_QLIMIT)  ? {1'b0, max_mod_ff} : uq_abs;
   assign mul_prod = mul_opd * mul_opd;

   assign sum_sq = {1'b0, ud2_ff} + {1'b0, b2_ff};

   // seed shift from radicand magnitude
   always_comb begin
      priority if (rad_ff < SEED_THR_LO) begin
         seed_sh = SEED_SH_LO;
      end else if (rad_ff < SEED_THR_MID) begin
         seed_sh = SEED_SH_MID;
      end else if (rad_ff < SEED_THR_HI) begin
         seed_sh = SEED_SH_HI;
      end else begin
         seed_sh = SEED_SH_TOP;
      end
   end

   // Newton update, sum wraps to 32 bits before halving
   assign newton_sum = {1'b0, x_ff} + {1'b0, div_quo};
   assign x_new      = {1'b0, newton_sum[31:1]};
   assign x_diff     = x_ff - x_new;
   assign n_next     = n_ff + 7'd1;

   // final estimate; saturated to 16 bits when the result is registered
   assign x_final = x_new;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      ud_in        = ud_ff;
      uq_in        = uq_ff;
      ud2_in       = ud2_ff;
      b2_in        = b2_ff;
      rad_in       = rad_ff;
      x_in         = x_ff;
      n_in         = n_ff;
      rsp_valid_in = 1'b0;
      rsp_root_in  = rsp_root_ff;
      div_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in    = req_opcode;
               ud_in    = req_ud;
               uq_in    = req_uq;
               state_in = ST_SQ_D;
            end
         end
         ST_SQ_D: begin
            ud2_in   = mul_prod[32:0];
            state_in = ST_SQ_B;
         end
         ST_SQ_B: begin
            b2_in    = mul_prod[32:0];
            state_in = ST_RAD;
         end
         ST_RAD: begin
            if (op_ff == OP_MAGNITUDE) begin
               rad_in = (sum_sq[33:32] != 2'b00) ? 32'hFFFF_FFFF : sum_sq[31:0];
            end else begin
               rad_in = (ud2_ff > b2_ff) ? 32'd0 : 32'(b2_ff - ud2_ff);
            end
            state_in = ST_SEED;
         end
         ST_SEED: begin
            x_in     = (rad_ff >> seed_sh) + 32'd1;
            n_in     = '0;
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_stat.done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            x_in = x_new;
            n_in = n_next;
            // carry on while still moving by more than one, under the step limit and not at zero
            if ((x_diff > 32'd1) && (n_next < STEP_LIMIT) && (x_new != 32'd0)) begin
               state_in = ST_DIV_GO;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_root_in  = (x_final > 32'h0000_FFFF) ? 16'hFFFF : x_final[15:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      ud_ff       <= ud_in;
      uq_ff       <= uq_in;
      ud2_ff      <= ud2_in;
      b2_ff       <= b2_in;
      rad_ff      <= rad_in;
      x_ff        <= x_in;
      n_ff        <= n_in;
      rsp_root_ff <= rsp_root_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_root  = rsp_root_ff;

   // checks
   a_strobe_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while sequencer busy");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not start the sequencer");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (x_ff != 32'd0))
      else $error("divider started with zero divisor");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIV_WAIT))
      else $error("divider finished outside the wait state");

endmodule
